// ===== src/binary_heap_priority_queue_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the binary heap priority queue
// Shared property wrappers; clk and rst_n must be in scope at the use site.
// ----------------------------------------------------------------------------
`ifndef BINARY_HEAP_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication.
`define BHPQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BHPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/bhpq_pkg.sv =====
// ----------------------------------------------------------------------------
// bhpq_pkg
// Shared types, sizes and codes of the binary heap priority queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bhpq_pkg;

  localparam int HEAP_SLOTS = 256;
  localparam int TAG_BITS   = 8;
  localparam int ADDR_W     = $clog2(HEAP_SLOTS);
  localparam int CNT_W      = ADDR_W + 1;

  localparam logic [CNT_W-1:0] CAPACITY = CNT_W'(HEAP_SLOTS - 1);

  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_EXTRACT = 2'd1;
  localparam logic [1:0] OP_UPDATE  = 2'd2;
  localparam logic [1:0] OP_CLEAR   = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_MISSING = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  tag;
    logic [31:0] cost;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_tag;
    logic [31:0] out_cost;
    logic [1:0]  status;
    logic [7:0]  entries;
  } out_item_t;

  typedef struct packed {
    logic [31:0]         cost;
    logic [TAG_BITS-1:0] tag;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    entry_t            wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } mem_req_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } seq_stat_t;

endpackage

// ===== src/bhpq_ram.sv =====
// ----------------------------------------------------------------------------
// bhpq_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bhpq_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 40
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/bhpq_seq.sv =====
// ----------------------------------------------------------------------------
// bhpq_seq
// Operation sequencer: tag search, sift up and sift down over the heap RAM.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "binary_heap_priority_queue_core_defines.svh"

module bhpq_seq
  import bhpq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  in_item_t  item,
  input  logic      res_ack,
  input  entry_t    rd_data,
  output mem_req_t  mem_req,
  output seq_stat_t stat,
  output out_item_t res
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_EXT_ROOT = 4'd1;
  localparam logic [3:0] S_EXT_LAST = 4'd2;
  localparam logic [3:0] S_SRCH     = 4'd3;
  localparam logic [3:0] S_RISE_RD  = 4'd4;
  localparam logic [3:0] S_RISE_CMP = 4'd5;
  localparam logic [3:0] S_SINK_RD  = 4'd6;
  localparam logic [3:0] S_SINK_L   = 4'd7;
  localparam logic [3:0] S_SINK_R   = 4'd8;
  localparam logic [3:0] S_FIN      = 4'd9;

  logic [3:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    pos_r, pos_nxt;
  logic [31:0]         c_r, c_nxt;
  logic [TAG_BITS-1:0] t_r, t_nxt;
  entry_t              left_r, left_nxt;
  logic [TAG_BITS-1:0] res_tag_r, res_tag_nxt;
  logic [31:0]         res_cost_r, res_cost_nxt;
  logic [1:0]          res_status_r, res_status_nxt;

  // shared cost comparator
  logic [31:0] cmp_a, cmp_b;
  logic        cmp_lt, cmp_eq;

  // sift-down child pick
  entry_t           child;
  logic [CNT_W-1:0] child_idx;
  logic [CNT_W-1:0] kid;
  logic             right_lt;

  assign kid      = pos_r << 1;
  assign right_lt = rd_data.cost < left_r.cost;

  always_comb begin
    if (state_r == S_SINK_R && right_lt) begin
      child     = rd_data;
      child_idx = kid | CNT_W'(1);
    end else if (state_r == S_SINK_R) begin
      child     = left_r;
      child_idx = kid;
    end else begin
      child     = rd_data;
      child_idx = kid;
    end
  end

  always_comb begin
    case (state_r)
      S_SINK_L, S_SINK_R: begin
        cmp_a = child.cost;
        cmp_b = c_r;
      end
      default: begin
        cmp_a = c_r;
        cmp_b = rd_data.cost;
      end
    endcase
  end

  assign cmp_lt = cmp_a < cmp_b;
  assign cmp_eq = cmp_a == cmp_b;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    pos_nxt        = pos_r;
    c_nxt          = c_r;
    t_nxt          = t_r;
    left_nxt       = left_r;
    res_tag_nxt    = res_tag_r;
    res_cost_nxt   = res_cost_r;
    res_status_nxt = res_status_r;
    mem_req        = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          res_tag_nxt    = '0;
          res_cost_nxt   = '0;
          res_status_nxt = ST_OK;
          c_nxt          = item.cost;
          t_nxt          = TAG_BITS'(item.tag);
          case (item.op)
            OP_INSERT: begin
              if (count_r >= CAPACITY) begin
                res_status_nxt = ST_FULL;
                state_nxt      = S_FIN;
              end else begin
                count_nxt = count_r + CNT_W'(1);
                pos_nxt   = count_r + CNT_W'(1);
                state_nxt = S_RISE_RD;
              end
            end
            OP_EXTRACT: begin
              if (count_r == '0) begin
                res_status_nxt = ST_EMPTY;
                state_nxt      = S_FIN;
              end else begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = ADDR_W'(1);
                state_nxt       = S_EXT_ROOT;
              end
            end
            OP_UPDATE: begin
              if (count_r == '0) begin
                res_status_nxt = ST_MISSING;
                state_nxt      = S_FIN;
              end else begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = ADDR_W'(1);
                pos_nxt         = CNT_W'(1);
                state_nxt       = S_SRCH;
              end
            end
            default: begin
              count_nxt = '0;
              state_nxt = S_FIN;
            end
          endcase
        end
      end

      S_EXT_ROOT: begin
        res_tag_nxt     = rd_data.tag;
        res_cost_nxt    = rd_data.cost;
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = count_r[ADDR_W-1:0];
        state_nxt       = S_EXT_LAST;
      end

      S_EXT_LAST: begin
        c_nxt     = rd_data.cost;
        t_nxt     = rd_data.tag;
        count_nxt = count_r - CNT_W'(1);
        pos_nxt   = CNT_W'(1);
        state_nxt = (count_r == CNT_W'(1)) ? S_FIN : S_SINK_RD;
      end

      // one slot per cycle; read of the next slot overlaps the tag compare
      S_SRCH: begin
        if (rd_data.tag == t_r) begin
          if (cmp_eq) begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = pos_r[ADDR_W-1:0];
            mem_req.wr_data = '{cost: c_r, tag: t_r};
            state_nxt       = S_FIN;
          end else if (cmp_lt) begin
            state_nxt = S_RISE_RD;
          end else begin
            state_nxt = S_SINK_RD;
          end
        end else if (pos_r == count_r) begin
          res_status_nxt = ST_MISSING;
          state_nxt      = S_FIN;
        end else begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = ADDR_W'(pos_r + CNT_W'(1));
          pos_nxt         = pos_r + CNT_W'(1);
        end
      end

      S_RISE_RD: begin
        if (pos_r > CNT_W'(1)) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = ADDR_W'(pos_r >> 1);
          state_nxt       = S_RISE_CMP;
        end else begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = pos_r[ADDR_W-1:0];
          mem_req.wr_data = '{cost: c_r, tag: t_r};
          state_nxt       = S_FIN;
        end
      end

      S_RISE_CMP: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = pos_r[ADDR_W-1:0];
        if (cmp_lt) begin
          // parent strictly greater: pull it down
          mem_req.wr_data = rd_data;
          pos_nxt         = pos_r >> 1;
          state_nxt       = S_RISE_RD;
        end else begin
          mem_req.wr_data = '{cost: c_r, tag: t_r};
          state_nxt       = S_FIN;
        end
      end

      S_SINK_RD: begin
        if (pos_r <= (count_r >> 1)) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = kid[ADDR_W-1:0];
          state_nxt       = S_SINK_L;
        end else begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = pos_r[ADDR_W-1:0];
          mem_req.wr_data = '{cost: c_r, tag: t_r};
          state_nxt       = S_FIN;
        end
      end

      S_SINK_L, S_SINK_R: begin
        if (state_r == S_SINK_L && kid < count_r) begin
          // right child exists: fetch it before deciding
          left_nxt        = rd_data;
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = ADDR_W'(kid | CNT_W'(1));
          state_nxt       = S_SINK_R;
        end else begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = pos_r[ADDR_W-1:0];
          if (cmp_lt) begin
            mem_req.wr_data = child;
            pos_nxt         = child_idx;
            state_nxt       = S_SINK_RD;
          end else begin
            mem_req.wr_data = '{cost: c_r, tag: t_r};
            state_nxt       = S_FIN;
          end
        end
      end

      S_FIN: begin
        if (res_ack) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    c_r          <= c_nxt;
    t_r          <= t_nxt;
    left_r       <= left_nxt;
    res_tag_r    <= res_tag_nxt;
    res_cost_r   <= res_cost_nxt;
    res_status_r <= res_status_nxt;
  end

  assign stat.idle      = state_r == S_IDLE;
  assign stat.res_valid = state_r == S_FIN;

  assign res.out_tag  = 8'(res_tag_r);
  assign res.out_cost = res_cost_r;
  assign res.status   = res_status_r;
  assign res.entries  = 8'(count_r);

  `BHPQ_ASSERT_NOW(a_count_cap, 1'b1, count_r <= CAPACITY, "entry count above capacity")
  `BHPQ_ASSERT_NOW(a_wr_in_heap, mem_req.wr_en,
    (CNT_W'(mem_req.wr_addr) != '0) && (CNT_W'(mem_req.wr_addr) <= count_r),
    "heap write outside occupied slots")
  `BHPQ_ASSERT_NOW(a_empty_status, stat.res_valid && (res.status == ST_EMPTY),
    count_r == '0, "empty status with entries present")
  `BHPQ_ASSERT_NOW(a_full_status, stat.res_valid && (res.status == ST_FULL),
    count_r == CAPACITY, "full status below capacity")
  `BHPQ_ASSERT_NEXT(a_clear_empties, start && stat.idle && (item.op == OP_CLEAR),
    count_r == '0, "clear left entries behind")

endmodule

// ===== src/binary_heap_priority_queue_core.sv =====
// ----------------------------------------------------------------------------
// binary_heap_priority_queue_core
// Min-cost binary heap with insert, extract-least, update-by-tag and clear.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one item per operation {op, tag, cost}; accepted on in_valid &&
//           in_ready. in_ready is high only while the sequencer is idle.
//   out_* : one result item per operation {out_tag, out_cost, status,
//           entries}, held in an output register until out_ready.
// Steps from accept to out_valid, per operation:
//   clear, full and empty   straight to the result, no heap access
//   insert                  sift up from the new last slot, stopping at the
//                           root or below a parent that is not greater
//   extract                 read the root and the last entry, then sift the
//                           last entry down from the root unless it was the only one
//   update                  search of the slots up to the match (a missing tag
//                           after the whole search), then the sift if the cost changed
// The heap RAM has a single read port, so parent and child entries are fetched
// one at a time, and the tag search walks the slots one per cycle.
// Throughput: one operation at a time; the next item is taken as soon as the
// sequencer is idle, even while the previous result waits in the output
// register. If the receiver stalls with a result still held, the sequencer
// holds its finished result until the register frees.
// Reset (synchronous, rst_n low) empties the queue; the RAM is not cleared,
// since slots beyond the entry count are never read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module binary_heap_priority_queue_core
  import bhpq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  mem_req_t         mem_req;
  seq_stat_t        stat;
  out_item_t        res;
  entry_t           rd_entry;
  logic [ENTRY_W-1:0] rd_raw;
  logic             res_ack;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;

  // heap storage: slot 0 unused, entries in slots 1..count
  bhpq_ram #(
    .DEPTH (HEAP_SLOTS),
    .WIDTH (ENTRY_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_req.wr_en),
    .wr_addr (mem_req.wr_addr),
    .wr_data (mem_req.wr_data),
    .rd_en   (mem_req.rd_en),
    .rd_addr (mem_req.rd_addr),
    .rd_data (rd_raw)
  );

  assign rd_entry = rd_raw;

  bhpq_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (in_valid && in_ready),
    .item    (in_data),
    .res_ack (res_ack),
    .rd_data (rd_entry),
    .mem_req (mem_req),
    .stat    (stat),
    .res     (res)
  );

  assign in_ready = stat.idle;

  // output register takes a result whenever it is empty or being drained
  assign res_ack = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (stat.res_valid && res_ack) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.res_valid && res_ack) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for binary_heap_priority_queue_core. A shadow min-heap
// follows every accepted item and queues the reply it should produce. Each
// reply is checked field by field, in order. Stimulus is a short directed
// run, then random churn with one pass that fills the heap and drains it.
// ----------------------------------------------------------------------------

module tb;
  import bhpq_pkg::*;

  localparam int RANDOM_ITEMS   = 1850;
  localparam int IDLE_PCT       = 8;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 60;
  localparam int MAX_REPORTS    = 40;

  logic      clk      = 1'b0;
  logic      rst_n    = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data  = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  binary_heap_priority_queue_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shadow heap: slots 1..shadow_count are live, slot 0 unused.
  // --------------------------------------------------------------------------
  logic [31:0]         shadow_cost [HEAP_SLOTS];
  logic [TAG_BITS-1:0] shadow_tag  [HEAP_SLOTS];
  int unsigned         shadow_count = 0;

  // Move up while the parent is strictly greater.
  function automatic void shadow_rise(int unsigned pos);
    logic [31:0]         c;
    logic [TAG_BITS-1:0] t;
    c = shadow_cost[pos];
    t = shadow_tag[pos];
    while (pos > 1 && shadow_cost[pos >> 1] > c) begin
      shadow_cost[pos] = shadow_cost[pos >> 1];
      shadow_tag[pos]  = shadow_tag[pos >> 1];
      pos = pos >> 1;
    end
    shadow_cost[pos] = c;
    shadow_tag[pos]  = t;
  endfunction

  // Right child only if strictly smaller; stop when entry <= child.
  function automatic void shadow_sink(int unsigned pos);
    logic [31:0]         c;
    logic [TAG_BITS-1:0] t;
    int unsigned         kid;
    bit                  settled;
    c = shadow_cost[pos];
    t = shadow_tag[pos];
    settled = 1'b0;
    while (!settled && pos <= (shadow_count >> 1)) begin
      kid = pos << 1;
      if (kid < shadow_count && shadow_cost[kid + 1] < shadow_cost[kid])
        kid++;
      if (c <= shadow_cost[kid]) begin
        settled = 1'b1;
      end else begin
        shadow_cost[pos] = shadow_cost[kid];
        shadow_tag[pos]  = shadow_tag[kid];
        pos = kid;
      end
    end
    shadow_cost[pos] = c;
    shadow_tag[pos]  = t;
  endfunction

  // Applies one operation to the shadow heap and returns the reply it causes.
  function automatic out_item_t heap_apply(in_item_t it);
    out_item_t           res;
    logic [TAG_BITS-1:0] key;
    logic [31:0]         old_cost;
    int unsigned         hit;
    int unsigned         i;
    res = '0;
    res.status = ST_OK;
    key = it.tag[TAG_BITS-1:0];
    hit = 0;
    case (it.op)
      OP_INSERT: begin
        if (shadow_count >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          shadow_count++;
          shadow_cost[shadow_count] = it.cost;
          shadow_tag[shadow_count]  = key;
          shadow_rise(shadow_count);
        end
      end
      OP_EXTRACT: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.out_tag  = 8'(shadow_tag[1]);
          res.out_cost = shadow_cost[1];
          shadow_cost[1] = shadow_cost[shadow_count];
          shadow_tag[1]  = shadow_tag[shadow_count];
          shadow_count--;
          if (shadow_count > 0) shadow_sink(1);
        end
      end
      OP_UPDATE: begin
        // lowest-numbered matching slot wins when tags repeat
        for (i = 1; i <= shadow_count && hit == 0; i++)
          if (shadow_tag[i] == key) hit = i;
        if (hit == 0) begin
          res.status = ST_MISSING;
        end else begin
          old_cost = shadow_cost[hit];
          shadow_cost[hit] = it.cost;
          if (it.cost > old_cost) shadow_sink(hit);
          else if (it.cost < old_cost) shadow_rise(hit);
        end
      end
      OP_CLEAR: shadow_count = 0;
      default: ;
    endcase
    res.entries = 8'(shadow_count);
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Operation script. plan_count tracks the entry count the script implies,
  // so phases can aim at a full or an empty heap.
  // --------------------------------------------------------------------------
  in_item_t    op_script[$];
  out_item_t   heap_replies[$];
  int unsigned plan_count    = 0;
  int unsigned planned_items = 0;

  function automatic void plan(logic [1:0] op, logic [7:0] tag, logic [31:0] cost);
    in_item_t it;
    it.op   = op;
    it.tag  = tag;
    it.cost = cost;
    op_script.push_back(it);
    planned_items++;
    case (op)
      OP_INSERT:  if (plan_count < CAPACITY) plan_count++;
      OP_EXTRACT: if (plan_count > 0) plan_count--;
      OP_CLEAR:   plan_count = 0;
      default: ;
    endcase
  endfunction

  // Dense small costs give plenty of ties; extremes hit every bit.
  function automatic logic [31:0] pick_cost();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 32'h0000_0000;
    else if (r < 20) return 32'hFFFF_FFFF;
    else if (r < 55) return 32'($urandom_range(0, 15));
    else return $urandom;
  endfunction

  // A narrow tag pool makes update hits and duplicate tags common.
  function automatic logic [7:0] pick_tag(bit narrow);
    if (narrow) return 8'($urandom_range(0, 15));
    else return 8'($urandom_range(0, 255));
  endfunction

  // Mixed traffic; the insert weight per phase lets the heap drift up or down.
  function automatic void churn_phase(int unsigned len);
    int unsigned ins_w;
    int unsigned r;
    bit          narrow;
    ins_w  = $urandom_range(30, 60);
    narrow = ($urandom_range(0, 3) != 0);
    repeat (len) begin
      r = $urandom_range(0, 99);
      if (r < ins_w) plan(OP_INSERT, pick_tag(narrow), pick_cost());
      else if (r < ins_w + 20) plan(OP_UPDATE, pick_tag(narrow), pick_cost());
      else if (r < 99) plan(OP_EXTRACT, 8'($urandom), $urandom);
      else plan(OP_CLEAR, 8'($urandom), $urandom);
    end
  endfunction

  // Fill to capacity, push past it, search a full heap, then drain past empty.
  function automatic void fill_phase();
    while (plan_count < CAPACITY) begin
      if ($urandom_range(0, 9) == 0) plan(OP_UPDATE, pick_tag(1'b0), pick_cost());
      else plan(OP_INSERT, pick_tag(1'b0), pick_cost());
    end
    repeat (3) plan(OP_INSERT, pick_tag(1'b0), pick_cost());
    repeat (6) plan(OP_UPDATE, pick_tag(1'b0), pick_cost());
    while (plan_count > 0) plan(OP_EXTRACT, 8'($urandom), $urandom);
    repeat (2) plan(OP_EXTRACT, 8'($urandom), $urandom);
  endfunction

  // --------------------------------------------------------------------------
  // Idling: each side idles about IDLE_PCT percent of the time, none at all
  // while a window of items goes through.
  // --------------------------------------------------------------------------
  int unsigned items_in   = 0;
  int unsigned items_out  = 0;
  int unsigned items_sent = 0;

  function automatic bit pause_roll();
    if (items_in >= 600 && items_in < 950) return 1'b0;
    return ($urandom_range(0, 99) < IDLE_PCT);
  endfunction

  // Driver: inputs change on the falling edge only.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      // valid holds its item until the rising edge that takes it
      if (!in_valid || items_in == items_sent) begin
        if (op_script.size() != 0 && !pause_roll()) begin
          in_valid <= 1'b1;
          in_data  <= op_script.pop_front();
          items_sent++;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= !pause_roll();
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: both handshakes sampled on the rising edge.
  // --------------------------------------------------------------------------
  int unsigned mismatch_count = 0;
  int unsigned op_seen[4]     = '{default: 0};
  int unsigned status_seen[4] = '{default: 0};
  int unsigned peak_entries   = 0;

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    if (mismatch_count < MAX_REPORTS)
      $display("[%0t] reply %0d: %s got 0x%0h, expected 0x%0h",
               $time, items_out, field, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        heap_replies.push_back(heap_apply(in_data));
        op_seen[in_data.op]++;
        items_in++;
      end
      if (out_valid && out_ready) begin
        if (heap_replies.size() == 0) begin
          report_mismatch("unsolicited reply, status", 32'(out_data.status), 32'h0);
        end else begin
          want = heap_replies.pop_front();
          if (out_data.out_tag !== want.out_tag)
            report_mismatch("out_tag", 32'(out_data.out_tag), 32'(want.out_tag));
          if (out_data.out_cost !== want.out_cost)
            report_mismatch("out_cost", out_data.out_cost, want.out_cost);
          if (out_data.status !== want.status)
            report_mismatch("status", 32'(out_data.status), 32'(want.status));
          if (out_data.entries !== want.entries)
            report_mismatch("entries", 32'(out_data.entries), 32'(want.entries));
          status_seen[want.status]++;
          if (want.entries > peak_entries) peak_entries = want.entries;
        end
        items_out++;
      end
    end
  end

  // Watchdog: too long without any handshake means the block is hung.
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] no handshake for %0d cycles, %0d replies outstanding",
               $time, quiet_cycles, heap_replies.size());
      $display("** binary_heap_priority_queue_core: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Script, reset and end of run.
  // --------------------------------------------------------------------------
  initial begin
    bit filled;
    filled = 1'b0;

    // empty-queue flags
    plan(OP_EXTRACT, 8'h00, 32'h0);
    plan(OP_UPDATE,  8'h05, 32'h1234);
    // extremes of tag and cost, alternating bit patterns, a duplicate tag
    plan(OP_INSERT,  8'h00, 32'hFFFF_FFFF);
    plan(OP_INSERT,  8'hFF, 32'h0000_0000);
    plan(OP_INSERT,  8'hAA, 32'h5555_5555);
    plan(OP_INSERT,  8'h55, 32'hAAAA_AAAA);
    plan(OP_INSERT,  8'hAA, 32'h5555_5555);
    // absent tag on a non-empty queue, then equal, lower and higher cost
    plan(OP_UPDATE,  8'h77, 32'h0);
    plan(OP_UPDATE,  8'hAA, 32'h5555_5555);
    plan(OP_UPDATE,  8'h00, 32'h0000_0001);
    plan(OP_UPDATE,  8'hFF, 32'hFFFF_FFFE);
    plan(OP_UPDATE,  8'hAA, 32'h0000_0000);
    repeat (6) plan(OP_EXTRACT, 8'hFF, 32'hFFFF_FFFF);
    // equal costs, then clear; stale slots must stay unread
    plan(OP_INSERT,  8'h01, 32'd7);
    plan(OP_INSERT,  8'h02, 32'd7);
    plan(OP_INSERT,  8'h03, 32'd7);
    plan(OP_CLEAR,   8'h00, 32'h0);
    plan(OP_EXTRACT, 8'h00, 32'h0);
    plan(OP_UPDATE,  8'h01, 32'd3);

    while (planned_items < RANDOM_ITEMS + 25) begin
      if (!filled && planned_items > 700) begin
        fill_phase();
        filled = 1'b1;
      end else begin
        churn_phase($urandom_range(40, 140));
      end
    end

    repeat (2) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (op_script.size() != 0 || in_valid || heap_replies.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d operations: %0d insert, %0d extract, %0d update, %0d clear; peak %0d entries.",
             items_in, op_seen[OP_INSERT], op_seen[OP_EXTRACT], op_seen[OP_UPDATE],
             op_seen[OP_CLEAR], peak_entries);
    $display("Flagged replies: %0d full, %0d empty, %0d tag missing; %0d field mismatches.",
             status_seen[ST_FULL], status_seen[ST_EMPTY], status_seen[ST_MISSING],
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("** binary_heap_priority_queue_core: PASSED **");
    end else begin
      $display("** binary_heap_priority_queue_core: FAILED **");
    end
    $finish;
  end

endmodule
